/* rtl/qapd_pkg.sv */
// Shared types and register codes for the quaternion attitude PD law.
// Used by quaternion_attitude_pd_law; depends on nothing.
package qapd_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_REF_W         = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_REF_X         = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_REF_Y         = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REF_Z         = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RATE_GAIN     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ATTITUDE_GAIN = 3'd5;

  localparam logic signed [23:0] TORQUE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] TORQUE_MIN = -24'sh800000;

  typedef struct packed {
    logic signed [15:0] meas_w;
    logic signed [15:0] meas_x;
    logic signed [15:0] meas_y;
    logic signed [15:0] meas_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } qapd_in_t;

  typedef struct packed {
    logic signed [23:0] torque_x;
    logic signed [23:0] torque_y;
    logic signed [23:0] torque_z;
  } qapd_out_t;

endpackage

/* rtl/quaternion_attitude_pd_law.sv */
// Quaternion-error attitude PD law: six-stage pipeline, top level.
// Depends on qapd_pkg for payload structs and register codes.
//
// A request is taken on every cycle that start is high; busy is always low.
// The torque result appears on out_data with out_valid high for one cycle,
// and the receiver cannot stall it. The result is registered through the
// pipeline stages in order: quaternion products, error sums, sign
// fold, gain multiplies, accumulate with rounding bias, then rounding and
// saturation. One request per cycle is sustained. Configuration writes
// take effect on the next cycle and should be made while no request is
// in flight.
module quaternion_attitude_pd_law
  import qapd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  qapd_in_t            in_data,
  output logic                out_valid,
  output qapd_out_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic signed [15:0] ref_q_r [4];
  logic [15:0]        rate_gain_r;
  logic [15:0]        attitude_gain_r;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic               accept;

  logic signed [15:0] meas [4];
  logic signed [15:0] rate [3];
  logic signed [16:0] kw_s;
  logic signed [16:0] kq_s;

  logic signed [31:0] p_r [4][4];
  logic signed [32:0] rp1_r [3];
  logic signed [33:0] e0_r;
  logic signed [33:0] ev_r [3];
  logic signed [32:0] rp2_r [3];
  logic signed [34:0] eva_r [3];
  logic signed [32:0] rp3_r [3];
  logic signed [51:0] att_r [3];
  logic signed [32:0] rp4_r [3];
  logic signed [51:0] acc_r [3];
  logic signed [23:0] tq_nxt [3];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign meas[0] = in_data.meas_w;
  assign meas[1] = in_data.meas_x;
  assign meas[2] = in_data.meas_y;
  assign meas[3] = in_data.meas_z;
  assign rate[0] = in_data.rate_x;
  assign rate[1] = in_data.rate_y;
  assign rate[2] = in_data.rate_z;
  assign kw_s    = signed'({1'b0, rate_gain_r});
  assign kq_s    = signed'({1'b0, attitude_gain_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_q_r[0]      <= 16'sd16384;
      ref_q_r[1]      <= 16'sd0;
      ref_q_r[2]      <= 16'sd0;
      ref_q_r[3]      <= 16'sd0;
      rate_gain_r     <= 16'd256;
      attitude_gain_r <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REF_W:         ref_q_r[0]      <= signed'(cfg_wdata);
        REG_REF_X:         ref_q_r[1]      <= signed'(cfg_wdata);
        REG_REF_Y:         ref_q_r[2]      <= signed'(cfg_wdata);
        REG_REF_Z:         ref_q_r[3]      <= signed'(cfg_wdata);
        REG_RATE_GAIN:     rate_gain_r     <= cfg_wdata;
        REG_ATTITUDE_GAIN: attitude_gain_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1_r      <= accept;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      out_valid <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p_r[i][j] <= ref_q_r[i] * meas[j];
      end
    end
    for (int k = 0; k < 3; k++) begin
      rp1_r[k] <= kw_s * rate[k];
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= 34'(p_r[0][0]) + 34'(p_r[1][1]) + 34'(p_r[2][2]) + 34'(p_r[3][3]);
    ev_r[0] <= 34'(p_r[1][0]) + 34'(p_r[3][2]) - 34'(p_r[0][1]) - 34'(p_r[2][3]);
    ev_r[1] <= 34'(p_r[1][3]) + 34'(p_r[2][0]) - 34'(p_r[0][2]) - 34'(p_r[3][1]);
    ev_r[2] <= 34'(p_r[2][1]) + 34'(p_r[3][0]) - 34'(p_r[0][3]) - 34'(p_r[1][2]);
    rp2_r   <= rp1_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      eva_r[k] <= e0_r[33] ? -35'(ev_r[k]) : 35'(ev_r[k]);
    end
    rp3_r <= rp2_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      att_r[k] <= kq_s * eva_r[k];
    end
    rp4_r <= rp3_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      acc_r[k] <= -(52'(rp4_r[k]) <<< 18) - att_r[k] + 52'sd8388608;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (signed'(acc_r[k][51:24]) > 28'(TORQUE_MAX)) begin
        tq_nxt[k] = TORQUE_MAX;
      end else if (signed'(acc_r[k][51:24]) < 28'(TORQUE_MIN)) begin
        tq_nxt[k] = TORQUE_MIN;
      end else begin
        tq_nxt[k] = acc_r[k][47:24];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data.torque_x <= tq_nxt[0];
    out_data.torque_y <= tq_nxt[1];
    out_data.torque_z <= tq_nxt[2];
  end

`ifndef SYNTHESIS
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_valid)
    else $error("request did not produce a result after six cycles");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##6 !out_valid)
    else $error("result strobe without a matching request");

  a_fold_sign: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && e0_r[33] && (ev_r[0] != 34'sd0) |=> (eva_r[0][34] != $past(ev_r[0][33])))
    else $error("error vector not folded to the shorter rotation");
`endif

endmodule

/* tb/tb_quaternion_attitude_pd_law.sv */
// Self-checking bench for quaternion_attitude_pd_law: directed and random requests
// under several register settings, checked against an in-bench torque predictor.
// Depends on qapd_pkg for the payload structs, register codes and torque bounds.
module tb_quaternion_attitude_pd_law;
  import qapd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_REQUESTS = 100;
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  class torque_scoreboard;
    logic signed [15:0] ref_w, ref_x, ref_y, ref_z;
    logic [15:0] rate_gain, attitude_gain;
    qapd_out_t torque_due[$];
    int errors, checked, requests, clipped;

    function new();
      ref_w = 16'sd16384;
      ref_x = '0;
      ref_y = '0;
      ref_z = '0;
      rate_gain = 16'd256;
      attitude_gain = 16'd256;
      errors = 0;
      checked = 0;
      requests = 0;
      clipped = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
      case (idx)
        REG_REF_W:         ref_w = v;
        REG_REF_X:         ref_x = v;
        REG_REF_Y:         ref_y = v;
        REG_REF_Z:         ref_z = v;
        REG_RATE_GAIN:     rate_gain = v;
        REG_ATTITUDE_GAIN: attitude_gain = v;
        default: ;
      endcase
    endfunction

    function logic signed [23:0] round_sat(longint acc);
      longint t;
      t = (acc + 64'sd8388608) >>> 24;
      if (t > TORQUE_MAX) begin
        clipped++;
        t = TORQUE_MAX;
      end else if (t < TORQUE_MIN) begin
        clipped++;
        t = TORQUE_MIN;
      end
      return t[23:0];
    endfunction

    function qapd_out_t predict_torque(qapd_in_t m);
      longint r0, r1, r2, r3, c0, c1, c2, c3, e0, kw, kq;
      longint ev[3];
      longint w[3];
      logic signed [23:0] tq[3];
      qapd_out_t res;
      r0 = ref_w;
      r1 = ref_x;
      r2 = ref_y;
      r3 = ref_z;
      c0 = m.meas_w;
      c1 = m.meas_x;
      c2 = m.meas_y;
      c3 = m.meas_z;
      c1 = -c1;
      c2 = -c2;
      c3 = -c3;
      kw = rate_gain;
      kq = attitude_gain;
      w[0] = m.rate_x;
      w[1] = m.rate_y;
      w[2] = m.rate_z;
      e0    = r0 * c0 - r1 * c1 - r2 * c2 - r3 * c3;
      ev[0] = r0 * c1 + r1 * c0 + r2 * c3 - r3 * c2;
      ev[1] = r0 * c2 - r1 * c3 + r2 * c0 + r3 * c1;
      ev[2] = r0 * c3 + r1 * c2 - r2 * c1 + r3 * c0;
      // take the shorter rotation
      if (e0 < 0) begin
        for (int i = 0; i < 3; i++) ev[i] = -ev[i];
      end
      for (int i = 0; i < 3; i++) tq[i] = round_sat(-(kw * w[i]) * 262144 - kq * ev[i]);
      res.torque_x = tq[0];
      res.torque_y = tq[1];
      res.torque_z = tq[2];
      return res;
    endfunction

    function void note_request(qapd_in_t m);
      requests++;
      torque_due.push_back(predict_torque(m));
    endfunction

    function void check_result(qapd_out_t got);
      qapd_out_t want;
      logic signed [23:0] e[3];
      logic signed [23:0] g[3];
      string names[3];
      if (torque_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                 got.torque_x, got.torque_y, got.torque_z);
        return;
      end
      want = torque_due.pop_front();
      checked++;
      e = '{want.torque_x, want.torque_y, want.torque_z};
      g = '{got.torque_x, got.torque_y, got.torque_z};
      names = '{"torque_x", "torque_y", "torque_z"};
      for (int i = 0; i < 3; i++) begin
        if (e[i] !== g[i]) begin
          errors++;
          $display("%0t: %s expected %0d got %0d", $time, names[i], e[i], g[i]);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  qapd_in_t in_data;
  logic out_valid;
  qapd_out_t out_data;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  torque_scoreboard sb = new();
  int cycles = 0;
  int settings = 1;

  quaternion_attitude_pd_law dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_quaternion_attitude_pd_law: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (start && !busy) sb.note_request(in_data);
      if (out_valid) sb.check_result(out_data);
    end
  end

  function automatic qapd_in_t mk(int w, int x, int y, int z, int rx, int ry, int rz);
    qapd_in_t d;
    d.meas_w = w[15:0];
    d.meas_x = x[15:0];
    d.meas_y = y[15:0];
    d.meas_z = z[15:0];
    d.rate_x = rx[15:0];
    d.rate_y = ry[15:0];
    d.rate_z = rz[15:0];
    return d;
  endfunction

  function automatic int rand_quat_part();
    case ($urandom_range(0, 7))
      0: return -16384;
      1: return 16384;
      2: return 0;
      3: return int'($urandom_range(0, 512)) - 256;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  function automatic int rand_rate();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return int'($urandom_range(0, 2048)) - 1024;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int rand_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return int'($urandom_range(0, 1024));
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  // one in four near the reference or its double cover (small error or sign fold)
  function automatic qapd_in_t rand_request();
    int sgn;
    if ($urandom_range(0, 3) == 0) begin
      sgn = $urandom_range(0, 1) ? 1 : -1;
      return mk(sgn * sb.ref_w + int'($urandom_range(0, 64)) - 32,
                sgn * sb.ref_x + int'($urandom_range(0, 64)) - 32,
                sgn * sb.ref_y + int'($urandom_range(0, 64)) - 32,
                sgn * sb.ref_z + int'($urandom_range(0, 64)) - 32,
                rand_rate(), rand_rate(), rand_rate());
    end
    return mk(rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part(),
              rand_rate(), rand_rate(), rand_rate());
  endfunction

  task automatic send_request(input qapd_in_t d);
    @(negedge clk);
    start <= 1'b1;
    in_data <= d;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle(input int n);
    logic [127:0] junk;
    repeat (n) begin
      @(negedge clk);
      junk = {$urandom, $urandom, $urandom, $urandom};
      start <= 1'b0;
      in_data <= junk[$bits(qapd_in_t)-1:0];
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.torque_due.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input int v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int w, input int x, input int y, input int z,
                            input int kw, input int kq);
    drain();
    cfg_write(REG_REF_W, w);
    cfg_write(REG_REF_X, x);
    cfg_write(REG_REF_Y, y);
    cfg_write(REG_REF_Z, z);
    cfg_write(REG_RATE_GAIN, kw);
    cfg_write(REG_ATTITUDE_GAIN, kq);
    if ($urandom_range(0, 1)) cfg_write(REG_SPARE_LO, $urandom);
    else cfg_write(REG_SPARE_HI, $urandom);
    settings++;
  endtask

  task automatic run_random_phase(input int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && sent < n) begin
        send_request(rand_request());
        sent++;
        burst--;
        if (sent == n / 2) drain();
      end
      idle($urandom_range(0, 6));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: identity reference, unit gains
    send_request(mk(0, 0, 0, 0, 0, 0, 0));
    send_request(mk(16384, 0, 0, 0, 0, 0, 0));
    send_request(mk(-16384, 0, 0, 0, 1, -1, 0));
    send_request(mk(0, 16384, 0, 0, 0, 0, 0));
    send_request(mk(0, 0, -16384, 16384, 32767, -32768, 32767));
    send_request(mk(16384, 16384, 16384, 16384, -32768, -32768, -32768));
    send_request(mk(-16384, -16384, -16384, -16384, 32767, 32767, 32767));
    send_request(mk(-1, 16384, -16384, 1, 0, 0, 0));
    send_request(mk(11585, 11585, 0, 0, 512, -512, 1));
    send_request(mk(-11585, 0, 11585, 0, -1, 1, -32768));
    idle(3);

    set_config(16384, 0, 0, 0, 65535, 65535);
    send_request(mk(16384, 0, 0, 0, 32767, -32768, 0));
    send_request(mk(0, 16384, -16384, 16384, 0, 0, 0));
    send_request(mk(-16384, 16384, 16384, -16384, -32768, 32767, 1));
    send_request(mk(16384, 16384, 16384, 16384, 32767, 32767, 32767));
    send_request(mk(0, 0, 0, 0, 1, -1, 2));
    send_request(mk(1, -16384, 0, 0, -2, 0, 0));

    set_config(-16384, 0, 0, 0, 0, 0);
    send_request(mk(16384, 16384, 16384, 16384, 32767, -32768, 32767));
    send_request(mk(-16384, -16384, 0, 16384, -32768, 32767, 0));
    send_request(mk(0, 0, 0, 0, 0, 0, 0));
    send_request(mk(1, 2, 3, 4, 5, 6, 7));

    set_config(-16384, 16384, -16384, 16384, 1, 65535);
    send_request(mk(16384, -16384, 16384, -16384, 32767, 0, -32768));
    send_request(mk(-16384, 16384, -16384, 16384, 0, 0, 0));
    send_request(mk(16384, 16384, 0, 0, -32768, 1, 32767));
    send_request(mk(0, 0, 16384, 16384, 100, -100, 0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_config(rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part(),
                 rand_gain(), rand_gain());
      run_random_phase(PHASE_REQUESTS);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d requests under %0d register settings, %0d results checked",
             sb.requests, settings, sb.checked);
    $display("%0d torque components clipped to the output range, %0d mismatches",
             sb.clipped, sb.errors);
    if (sb.errors == 0 && sb.torque_due.size() == 0) begin
      $display("tb_quaternion_attitude_pd_law: PASS");
    end else begin
      $display("tb_quaternion_attitude_pd_law: FAIL");
    end
    $finish;
  end

endmodule
